// ----- hdl/pbc_pkg.sv -----
`default_nettype none

package pbc_pkg;

  // Character codes of interest
  localparam logic [7:0] CHAR_OPEN    = 8'h28;
  localparam logic [7:0] CHAR_CLOSE   = 8'h29;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

  // Input kind
  localparam logic KIND_TEXT = 1'b0;
  localparam logic KIND_EOS  = 1'b1;

  // Width of the line field on the result port
  localparam int OUT_LINE_W = 16;

  // Operations passed from front to back
  typedef enum logic [1:0] {
    OP_OPEN,
    OP_CLOSE,
    OP_EOS
  } op_t;

  // Result report codes
  typedef enum logic [1:0] {
    REP_EXTRA_CLOSE     = 2'd0,
    REP_UNBALANCED_OPEN = 2'd1,
    REP_OVERFLOW        = 2'd2,
    REP_DONE            = 2'd3
  } rep_t;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    ST_RUN,
    ST_FLUSH,
    ST_DONE
  } bstate_t;

  // One result word
  typedef struct packed {
    rep_t                  report;
    logic [OUT_LINE_W-1:0] line_number;
    logic                  balanced;
    logic                  last;
  } res_t;

endpackage

`default_nettype wire

// ----- hdl/pbc_ram.sv -----
`default_nettype none

module pbc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- hdl/pbc_fifo.sv -----
`default_nettype none

// Small register queue, DEPTH a power of two >= 2.
module pbc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  fifo_empty,
  output logic                  fifo_full
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign fifo_empty = (cnt_r == '0);
  assign fifo_full  = (cnt_r == CW'(DEPTH));
  assign do_wr      = wr_en && !fifo_full;
  assign do_rd      = rd_en && !fifo_empty;
  assign rd_data    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + PW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/pbc_front.sv -----
`default_nettype none

// Classifies input words, tracks the line counter, queues ops for the back end.
module pbc_front #(
  parameter int LINE_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_push,
  input  wire logic                 in_kind,
  input  wire logic [7:0]           in_char_code,
  input  wire logic                 opq_full,
  output logic                      in_full,
  output logic                      opq_we,
  output pbc_pkg::op_t              opq_op,
  output logic      [LINE_BITS-1:0] opq_line
);

  import pbc_pkg::*;

  localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);
  localparam logic [LINE_BITS-1:0] LINE_TOP = '1;

  logic [LINE_BITS-1:0] line_r, line_nxt;
  logic                 accept;

  assign in_full  = opq_full;
  assign accept   = in_push && !opq_full;
  assign opq_line = line_r;

  always_comb begin
    line_nxt = line_r;
    opq_we   = 1'b0;
    opq_op   = OP_OPEN;
    if (accept) begin
      if (in_kind == KIND_EOS) begin
        opq_we   = 1'b1;
        opq_op   = OP_EOS;
        line_nxt = LINE_ONE;
      end else if (in_char_code == CHAR_NEWLINE) begin
        if (line_r != LINE_TOP) begin
          line_nxt = line_r + LINE_ONE;
        end
      end else if (in_char_code == CHAR_OPEN) begin
        opq_we = 1'b1;
        opq_op = OP_OPEN;
      end else if (in_char_code == CHAR_CLOSE) begin
        opq_we = 1'b1;
        opq_op = OP_CLOSE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r <= LINE_ONE;
    end else begin
      line_r <= line_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/pbc_back.sv -----
`default_nettype none

// Executes queued ops against the line stack and produces result words.
module pbc_back #(
  parameter int STACK_DEPTH = 32,
  parameter int LINE_BITS   = 16,
  parameter int AW          = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 op_valid,
  input  wire pbc_pkg::op_t         op,
  input  wire logic [LINE_BITS-1:0] op_line,
  output logic                      op_pop,
  input  wire logic                 res_full,
  output logic                      res_we,
  output pbc_pkg::res_t             res,
  output logic                      ram_we,
  output logic      [AW-1:0]        ram_waddr,
  output logic      [LINE_BITS-1:0] ram_wdata,
  output logic                      ram_re,
  output logic      [AW-1:0]        ram_raddr,
  input  wire logic [LINE_BITS-1:0] ram_rdata
);

  import pbc_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);

  bstate_t       state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] count_dec;
  logic          err_r, err_nxt;

  logic [LINE_BITS+OUT_LINE_W-1:0] op_line_ext, rd_line_ext;

  // zero-extend then cut to the port width, valid for any LINE_BITS
  assign op_line_ext = {{OUT_LINE_W{1'b0}}, op_line};
  assign rd_line_ext = {{OUT_LINE_W{1'b0}}, ram_rdata};
  assign count_dec   = count_r - CW'(1);
  assign ram_waddr   = count_r[AW-1:0];
  assign ram_wdata   = op_line;
  assign ram_raddr   = count_dec[AW-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_RUN: begin
        if (op_valid && op == OP_EOS && count_r != '0) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!res_full && count_r == '0) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!res_full) begin
          state_nxt = ST_RUN;
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  // outputs and datapath
  always_comb begin
    op_pop    = 1'b0;
    res_we    = 1'b0;
    res       = '0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    count_nxt = count_r;
    err_nxt   = err_r;
    unique case (state_r)
      ST_RUN: begin
        if (op_valid) begin
          unique case (op)
            OP_OPEN: begin
              if (count_r < CW'(STACK_DEPTH)) begin
                ram_we    = 1'b1;
                count_nxt = count_r + CW'(1);
                op_pop    = 1'b1;
              end else if (!res_full) begin
                res_we          = 1'b1;
                res.report      = REP_OVERFLOW;
                res.line_number = op_line_ext[OUT_LINE_W-1:0];
                res.last        = 1'b1;
                err_nxt         = 1'b1;
                op_pop          = 1'b1;
              end
            end
            OP_CLOSE: begin
              if (count_r != '0) begin
                count_nxt = count_dec;
                op_pop    = 1'b1;
              end else if (!res_full) begin
                res_we          = 1'b1;
                res.report      = REP_EXTRA_CLOSE;
                res.line_number = op_line_ext[OUT_LINE_W-1:0];
                res.last        = 1'b1;
                err_nxt         = 1'b1;
                op_pop          = 1'b1;
              end
            end
            OP_EOS: begin
              if (count_r != '0) begin
                // start the flush: fetch the top entry
                ram_re    = 1'b1;
                count_nxt = count_dec;
              end else if (!res_full) begin
                res_we          = 1'b1;
                res.report      = REP_DONE;
                res.line_number = op_line_ext[OUT_LINE_W-1:0];
                res.balanced    = !err_r;
                res.last        = 1'b1;
                err_nxt         = 1'b0;
                op_pop          = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FLUSH: begin
        if (!res_full) begin
          res_we          = 1'b1;
          res.report      = REP_UNBALANCED_OPEN;
          res.line_number = rd_line_ext[OUT_LINE_W-1:0];
          err_nxt         = 1'b1;
          if (count_r != '0) begin
            ram_re    = 1'b1;
            count_nxt = count_dec;
          end
        end
      end
      ST_DONE: begin
        if (!res_full) begin
          res_we          = 1'b1;
          res.report      = REP_DONE;
          res.line_number = op_line_ext[OUT_LINE_W-1:0];
          res.balanced    = !err_r;
          res.last        = 1'b1;
          err_nxt         = 1'b0;
          op_pop          = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
      count_r <= '0;
      err_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/paren_balance_checker.sv -----
`default_nettype none

// Channel   Handshake           Payload                                  Dir
// input     push / full         in_kind, in_char_code                    in
// result    empty / pop         out_report, out_line_number,             out
//                               out_balanced, out_last
//
// Rate: one text word per cycle while full is low. An end-of-stream word
//   with open entries on the stack starts a flush: one stack read to start,
//   one unbalanced-open result per entry, then done; with none it gives done.
//   The flush speed is set by the single read port of the stack RAM.
// Path: a word's op is registered in the op queue and its result in the result queue.
// Reset: synchronous, clears queues, stack count, line counter (to 1) and
//   error flag. The stack RAM is not cleared; only pushed entries are read.
// Stalls: a full op queue raises full; a full result queue stalls only the
//   back end, words keep entering until the op queue fills.
module paren_balance_checker #(
  parameter int STACK_DEPTH = 32,
  parameter int LINE_BITS   = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        push,
  output logic             full,
  input  wire logic        in_kind,
  input  wire logic [7:0]  in_char_code,
  // result channel
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       out_report,
  output logic [15:0]      out_line_number,
  output logic             out_balanced,
  output logic             out_last
);

  import pbc_pkg::*;

  localparam int AW       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int OPQ_W    = $bits(op_t) + LINE_BITS;
  localparam int OPQ_D    = 4;
  localparam int RESQ_W   = $bits(res_t);
  localparam int RESQ_D   = 2;

  // front -> op queue
  logic                 opq_we, opq_full, opq_empty, op_pop;
  op_t                  fr_op;
  logic [LINE_BITS-1:0] fr_line;
  logic [OPQ_W-1:0]     opq_rd;
  op_t                  bk_op;
  logic [LINE_BITS-1:0] bk_line;

  // back -> result queue
  logic                 res_we, res_full;
  res_t                 res, res_head;
  logic [RESQ_W-1:0]    resq_rd;

  // stack RAM
  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [LINE_BITS-1:0] ram_wdata, ram_rdata;

  pbc_front #(
    .LINE_BITS (LINE_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (push),
    .in_kind      (in_kind),
    .in_char_code (in_char_code),
    .opq_full     (opq_full),
    .in_full      (full),
    .opq_we       (opq_we),
    .opq_op       (fr_op),
    .opq_line     (fr_line)
  );

  // op queue decouples classification from stack work
  pbc_fifo #(
    .WIDTH (OPQ_W),
    .DEPTH (OPQ_D)
  ) u_opq (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (opq_we),
    .wr_data    ({fr_op, fr_line}),
    .rd_en      (op_pop),
    .rd_data    (opq_rd),
    .fifo_empty (opq_empty),
    .fifo_full  (opq_full)
  );

  assign bk_op   = op_t'(opq_rd[OPQ_W-1 -: $bits(op_t)]);
  assign bk_line = opq_rd[LINE_BITS-1:0];

  pbc_back #(
    .STACK_DEPTH (STACK_DEPTH),
    .LINE_BITS   (LINE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (!opq_empty),
    .op        (bk_op),
    .op_line   (bk_line),
    .op_pop    (op_pop),
    .res_full  (res_full),
    .res_we    (res_we),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  pbc_ram #(
    .WIDTH (LINE_BITS),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // result queue: output side of the block
  pbc_fifo #(
    .WIDTH (RESQ_W),
    .DEPTH (RESQ_D)
  ) u_resq (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (res_we),
    .wr_data    (res),
    .rd_en      (pop),
    .rd_data    (resq_rd),
    .fifo_empty (empty),
    .fifo_full  (res_full)
  );

  assign res_head        = res_t'(resq_rd);
  assign out_report      = res_head.report;
  assign out_line_number = res_head.line_number;
  assign out_balanced    = res_head.balanced;
  assign out_last        = res_head.last;

  // back end only writes results when there is room
  a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_we |-> !res_full)
    else $error("result written into full queue");

  // back end only consumes ops that are present
  a_op_present: assert property (@(posedge clk) disable iff (!rst_n)
    op_pop |-> !opq_empty)
    else $error("op popped from empty queue");

  // done closes every stream's result group; balanced only on done
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (res_we && (res.report == REP_DONE || res.balanced)) |->
      (res.last && res.report == REP_DONE))
    else $error("done word malformed");

  // stack writes never happen during a flush read
  a_no_rw: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !ram_re)
    else $error("stack written during flush");

endmodule

`default_nettype wire
